// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every rising edge outside of reset
`define ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// checked on every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rstn, prop)
`define ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== src/vdd_pkg.sv =====
// ----------------------------------------------------------------------------
// vdd_pkg
// Shared constants, register indexes and pipeline word types of the
// voxel dissolve block.
// ----------------------------------------------------------------------------
package vdd_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int DATA_WIDTH = 16;

  // dissolve_speed register width and the step quotient width
  localparam int SPD_W  = 13;
  localparam int STEP_W = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(STEP_W);
  localparam int CMP_W  = (DATA_WIDTH > STEP_W) ? DATA_WIDTH : STEP_W;
  localparam int PROD_W = DATA_WIDTH + CMP_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SPD_W;

  localparam logic [STEP_W-1:0] OneFix = STEP_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED    = 2'd0,
    REG_EXP_MODE = 2'd1,
    REG_HEAT_EN  = 2'd2,
    REG_COLOR_EN = 2'd3
  } vdd_reg_e;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [PROD_W-1:0]     prod_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              exp_mode;
    logic              heat_en;
    logic              color_en;
    logic              busy;
  } vdd_cfg_t;

  // one voxel; heat is carried as raw two's complement bits
  typedef struct packed {
    data_t density;
    data_t heat;
    data_t red;
    data_t green;
    data_t blue;
    logic  last;
  } vdd_item_t;

  typedef struct packed {
    data_t             density;
    data_t             nd_lin;
    data_t             heat_raw;
    data_t             heat_lin;
    data_t             hmag;
    logic              hneg;
    data_t [2:0]       col;
    logic              last;
    logic [STEP_W-1:0] fac;
  } vdd_prep_t;

  typedef struct packed {
    data_t       density;
    data_t       nd_lin;
    data_t       heat_raw;
    data_t       heat_lin;
    logic        hneg;
    prod_t       pd;
    prod_t       ph;
    prod_t [2:0] pc;
    data_t [2:0] col_raw;
    logic        last;
  } vdd_mul_t;

endpackage

// ===== src/vdd_intf.sv =====
// ----------------------------------------------------------------------------
// vdd_in_if / vdd_out_if
// Valid/ready channels carrying one voxel word in and one word out.
// ----------------------------------------------------------------------------
interface vdd_in_if import vdd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [DATA_WIDTH-1:0]        density_in;
  logic signed [DATA_WIDTH-1:0] heat_in;
  logic [DATA_WIDTH-1:0]        red_in;
  logic [DATA_WIDTH-1:0]        green_in;
  logic [DATA_WIDTH-1:0]        blue_in;
  logic                         last_cell_in;

  modport source (
    output valid, density_in, heat_in, red_in, green_in, blue_in, last_cell_in,
    input  ready
  );
  modport sink (
    input  valid, density_in, heat_in, red_in, green_in, blue_in, last_cell_in,
    output ready
  );
endinterface

interface vdd_out_if import vdd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [DATA_WIDTH-1:0]        density_out;
  logic signed [DATA_WIDTH-1:0] heat_out;
  logic [DATA_WIDTH-1:0]        red_out;
  logic [DATA_WIDTH-1:0]        green_out;
  logic [DATA_WIDTH-1:0]        blue_out;
  logic                         last_cell_out;

  modport source (
    output valid, density_out, heat_out, red_out, green_out, blue_out, last_cell_out,
    input  ready
  );
  modport sink (
    input  valid, density_out, heat_out, red_out, green_out, blue_out, last_cell_out,
    output ready
  );
endinterface

// ===== src/voxel_density_dissolve.sv =====
// ----------------------------------------------------------------------------
// voxel_density_dissolve
// Dissolves one voxel per word by one frame step in exponential or linear
// falloff, with optional heat decay and color rescaling.
// ----------------------------------------------------------------------------
// Takes one voxel word per clock when not stalled and returns one word per
// voxel, in order, through three front stages (input register, linear
// arithmetic, multipliers), one result-select stage, one stage per quotient
// bit of the 16-bit color divider, and the output register. Writing
// dissolve_speed starts a bit-serial computation of the step; the input is
// held off (ready low) until it finishes. Other registers take effect at once.
// The user must write registers only while no voxel is in flight; unenforced.

`include "assert_macros.svh"

module voxel_density_dissolve import vdd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vdd_in_if.sink                in_ch,
  vdd_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SPD_W-1:0]  dissolve_speed_q;
  logic              exp_mode_q;
  logic              heat_en_q;
  logic              color_en_q;
  logic              speed_wr;
  logic              step_busy;
  logic [STEP_W-1:0] step;
  logic              step_ok;
  vdd_cfg_t          cfg;

  vdd_item_t in_item;
  logic      front_ready;
  logic      mul_valid, mul_ready;
  vdd_mul_t  mul_word;
  logic      res_valid, res_ready;
  vdd_item_t res_word;

  logic      out_valid_q;
  vdd_item_t out_res_q;

  // register file
  assign speed_wr = cfg_we_i && (vdd_reg_e'(cfg_idx_i) == REG_SPEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dissolve_speed_q <= SPD_W'(1);
      exp_mode_q       <= 1'b0;
      heat_en_q        <= 1'b0;
      color_en_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (vdd_reg_e'(cfg_idx_i))
        REG_SPEED:    dissolve_speed_q <= cfg_data_i[SPD_W-1:0];
        REG_EXP_MODE: exp_mode_q       <= cfg_data_i[0];
        REG_HEAT_EN:  heat_en_q        <= cfg_data_i[0];
        REG_COLOR_EN: color_en_q       <= cfg_data_i[0];
      endcase
    end
  end

  vdd_step_div u_step_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (speed_wr),
    .speed_i (dissolve_speed_q),
    .busy_o  (step_busy),
    .step_o  (step)
  );

  always_comb begin
    cfg.step     = step;
    cfg.exp_mode = exp_mode_q;
    cfg.heat_en  = heat_en_q;
    cfg.color_en = color_en_q;
    cfg.busy     = step_busy;
  end

  always_comb begin
    in_item.density = in_ch.density_in;
    in_item.heat    = data_t'(in_ch.heat_in);
    in_item.red     = in_ch.red_in;
    in_item.green   = in_ch.green_in;
    in_item.blue    = in_ch.blue_in;
    in_item.last    = in_ch.last_cell_in;
  end

  assign in_ch.ready = front_ready && !cfg.busy;

  vdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_ch.valid && !cfg.busy),
    .in_ready_o  (front_ready),
    .in_item_i   (in_item),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_mul_o   (mul_word)
  );

  vdd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_mul_i    (mul_word),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_res_o   (res_word)
  );

  // output register decouples the pipe from the downstream ready
  assign res_ready = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res_word;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.density_out   = out_res_q.density;
  assign out_ch.heat_out      = $signed(out_res_q.heat);
  assign out_ch.red_out       = out_res_q.red;
  assign out_ch.green_out     = out_res_q.green;
  assign out_ch.blue_out      = out_res_q.blue;
  assign out_ch.last_cell_out = out_res_q.last;

  // a finished step is zero only for speeds beyond one frame
  assign step_ok = (dissolve_speed_q > OneFix) || (step != '0);

  // assertions
  `ASSERT_ALWAYS(a_step_range, clk_i, step <= OneFix)
  `ASSERT_RST(a_busy_from_write, clk_i, rst_ni, $rose(step_busy) |-> $past(speed_wr))
  `ASSERT_RST(a_step_nonzero, clk_i, rst_ni, $fell(step_busy) |-> step_ok)
  `ASSERT_RST(a_no_accept_busy, clk_i, rst_ni, in_ch.ready |-> !step_busy)

endmodule

// ===== src/vdd_step_div.sv =====
// ----------------------------------------------------------------------------
// vdd_step_div
// Bit-serial divider computing step = floor(ONE / speed) after a write of
// the speed register, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vdd_step_div import vdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SPD_W-1:0]  speed_i,
  output logic              busy_o,
  output logic [STEP_W-1:0] step_o
);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SPD_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;

  logic [SPD_W-1:0] spd;
  logic [SPD_W:0]   trial;
  logic [SPD_W:0]   spd_ext;
  logic             num_bit;
  logic             ge;

  always_comb begin
    // speed zero behaves as one
    spd     = (speed_i == '0) ? SPD_W'(1) : speed_i;
    spd_ext = {1'b0, spd};
    // numerator ONE has a single set bit
    num_bit = (cnt_q == CNT_W'(FRAC_BITS));
    trial   = {rem_q, num_bit};
    ge      = (trial >= spd_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      step_q <= OneFix;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(STEP_W - 1);
      rem_q  <= '0;
      step_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? SPD_W'(trial - spd_ext) : trial[SPD_W-1:0];
      step_q <= {step_q[STEP_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign step_o = step_q;

endmodule

// ===== src/vdd_front.sv =====
// ----------------------------------------------------------------------------
// vdd_front
// Input register, linear-mode arithmetic and the multiplier stage.
// ----------------------------------------------------------------------------
module vdd_front import vdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vdd_cfg_t  cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  vdd_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vdd_mul_t  out_mul_o
);

  logic      v1_q, v2_q, v3_q;
  vdd_item_t s1_q;
  vdd_prep_t s2_q, s2_d;
  vdd_mul_t  s3_q, s3_d;
  logic      adv;

  logic [CMP_W-1:0] dens_ext;
  logic [CMP_W-1:0] step_ext;
  logic [CMP_W-1:0] hmag_ext;
  data_t            hmag;
  data_t            hdiff;
  logic             hneg;
  logic [CMP_W-1:0] mul_b;
  logic [CMP_W-1:0] fac_ext;

  // whole pipe moves when the last word can leave
  assign adv = !v3_q || out_ready_i;

  // stage 2: linear falloff and heat magnitude
  always_comb begin
    dens_ext = CMP_W'(s1_q.density);
    step_ext = CMP_W'(cfg_i.step);
    hneg     = s1_q.heat[DATA_WIDTH-1];
    hmag     = hneg ? data_t'(~s1_q.heat + 1'b1) : s1_q.heat;
    hmag_ext = CMP_W'(hmag);
    hdiff    = data_t'(hmag_ext - step_ext);

    s2_d.density  = s1_q.density;
    s2_d.nd_lin   = (dens_ext > step_ext) ? data_t'(dens_ext - step_ext) : '0;
    s2_d.heat_raw = s1_q.heat;
    s2_d.heat_lin = (hmag_ext < step_ext) ? '0 :
                    (hneg ? data_t'(~hdiff + 1'b1) : hdiff);
    s2_d.hmag     = hmag;
    s2_d.hneg     = hneg;
    s2_d.col[0]   = s1_q.red;
    s2_d.col[1]   = s1_q.green;
    s2_d.col[2]   = s1_q.blue;
    s2_d.last     = s1_q.last;
    s2_d.fac      = OneFix - cfg_i.step;
  end

  // stage 3: products; colors use fac or new density depending on mode
  always_comb begin
    fac_ext = CMP_W'(s2_q.fac);
    mul_b   = cfg_i.exp_mode ? fac_ext : CMP_W'(s2_q.nd_lin);

    s3_d.density  = s2_q.density;
    s3_d.nd_lin   = s2_q.nd_lin;
    s3_d.heat_raw = s2_q.heat_raw;
    s3_d.heat_lin = s2_q.heat_lin;
    s3_d.hneg     = s2_q.hneg;
    s3_d.pd       = prod_t'(s2_q.density) * prod_t'(fac_ext);
    s3_d.ph       = prod_t'(s2_q.hmag) * prod_t'(fac_ext);
    for (int i = 0; i < 3; i++) begin
      s3_d.pc[i]      = prod_t'(s2_q.col[i]) * prod_t'(mul_b);
      s3_d.col_raw[i] = s2_q.col[i];
    end
    s3_d.last     = s2_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_q <= in_item_i;
    end
    if (adv && v1_q) begin
      s2_q <= s2_d;
    end
    if (adv && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = v3_q;
  assign out_mul_o   = s3_q;

endmodule

// ===== src/vdd_div.sv =====
// ----------------------------------------------------------------------------
// vdd_div
// Result selection for density and heat, then a pipelined restoring divider
// (one quotient bit per stage) for the three color rescales.
// ----------------------------------------------------------------------------
module vdd_div import vdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vdd_cfg_t  cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  vdd_mul_t  in_mul_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vdd_item_t out_res_o
);

  localparam int NSTG = DATA_WIDTH;

  typedef struct packed {
    data_t       density;
    data_t       heat;
    data_t [2:0] col;
    logic        use_div;
    data_t       divisor;
    logic        last;
  } side_t;

  // partial remainder and numerator bits / quotient bits sharing one register
  typedef struct packed {
    data_t rem;
    data_t acc;
  } lane_t;

  function automatic lane_t div_step(lane_t l, data_t d);
    logic [DATA_WIDTH:0] t;
    logic [DATA_WIDTH:0] dx;
    logic                ge;
    lane_t               r;
    t     = {l.rem, l.acc[DATA_WIDTH-1]};
    dx    = {1'b0, d};
    ge    = (t >= dx);
    r.rem = ge ? data_t'(t - dx) : t[DATA_WIDTH-1:0];
    r.acc = {l.acc[DATA_WIDTH-2:0], ge};
    return r;
  endfunction

  logic [NSTG:0] v_q;
  side_t         side_q [NSTG+1];
  lane_t [2:0]   lane_q [NSTG+1];
  side_t         side_d;
  lane_t [2:0]   lane_d;
  data_t         hs;
  data_t         heat_exp;
  logic          adv;

  assign adv = !v_q[NSTG] || out_ready_i;

  // entry: finish density and heat, set up the color divisions
  always_comb begin
    hs       = data_t'(in_mul_i.ph >> FRAC_BITS);
    heat_exp = in_mul_i.hneg ? data_t'(~hs + 1'b1) : hs;

    side_d.density = cfg_i.exp_mode ? data_t'(in_mul_i.pd >> FRAC_BITS) : in_mul_i.nd_lin;
    side_d.heat    = !cfg_i.heat_en ? in_mul_i.heat_raw :
                     (cfg_i.exp_mode ? heat_exp : in_mul_i.heat_lin);
    for (int i = 0; i < 3; i++) begin
      side_d.col[i] = (cfg_i.exp_mode && cfg_i.color_en) ?
                      data_t'(in_mul_i.pc[i] >> FRAC_BITS) : in_mul_i.col_raw[i];
      lane_d[i].rem = in_mul_i.pc[i][2*DATA_WIDTH-1:DATA_WIDTH];
      lane_d[i].acc = in_mul_i.pc[i][DATA_WIDTH-1:0];
    end
    // zero old density leaves the colors as they are
    side_d.use_div = !cfg_i.exp_mode && cfg_i.color_en && (in_mul_i.density != '0);
    side_d.divisor = in_mul_i.density;
    side_d.last    = in_mul_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      side_q[0] <= side_d;
      lane_q[0] <= lane_d;
    end
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (adv && v_q[k-1]) begin
        side_q[k] <= side_q[k-1];
        for (int i = 0; i < 3; i++) begin
          lane_q[k][i] <= div_step(lane_q[k-1][i], side_q[k-1].divisor);
        end
      end
    end
  end

  always_comb begin
    out_res_o.density = side_q[NSTG].density;
    out_res_o.heat    = side_q[NSTG].heat;
    out_res_o.red     = side_q[NSTG].use_div ? lane_q[NSTG][0].acc : side_q[NSTG].col[0];
    out_res_o.green   = side_q[NSTG].use_div ? lane_q[NSTG][1].acc : side_q[NSTG].col[1];
    out_res_o.blue    = side_q[NSTG].use_div ? lane_q[NSTG][2].acc : side_q[NSTG].col[2];
    out_res_o.last    = side_q[NSTG].last;
  end

  assign in_ready_o  = adv;
  assign out_valid_o = v_q[NSTG];

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voxel dissolve block: random voxel streams
// under changing register settings, bursty input and a stalling output.
// Every word is compared against a local prediction of the dissolve step.
// ----------------------------------------------------------------------------
module tb import vdd_pkg::*; ();

  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 100;
  localparam int NumPhases  = 16;
  localparam int HoldCycles = 300;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  // fields: density, heat, red, green, blue, last
  localparam vdd_item_t ProbeVoxels [5] = '{
    {16'h0000, 16'h8000, 16'hFFFF, 16'h0000, 16'h1234, 1'b1},
    {16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
    {16'h0800, 16'hFFFF, 16'h0FFF, 16'h8000, 16'h0001, 1'b1},
    {16'h1000, 16'h0064, 16'h1000, 16'h2000, 16'h3000, 1'b0},
    {16'h0001, 16'hFF9C, 16'hABCD, 16'h5555, 16'hAAAA, 1'b1}
  };
  // speed zero, largest speed (beyond one frame), small speed, speed of one frame
  localparam logic [CFG_DATA_W-1:0] ProbeSpeed [4] = '{13'd0, 13'd8191, 13'd3, 13'd4096};
  localparam logic [3:0] ProbeExp   = 4'b1010;
  localparam logic [3:0] ProbeHeat  = 4'b1011;
  localparam logic [3:0] ProbeColor = 4'b1001;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  vdd_in_if  in_ch ();
  vdd_out_if out_ch ();

  voxel_density_dissolve u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // local copy of the register file
  logic [CFG_DATA_W-1:0] speed_cfg = 13'd1;
  logic                  exp_cfg   = 1'b0;
  logic                  heat_cfg  = 1'b0;
  logic                  color_cfg = 1'b0;

  vdd_item_t voxel_q[$];
  vdd_item_t dissolved_q[$];
  int        fail_cnt = 0;
  longint    cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] decay_step();
    logic [63:0] unity;
    unity = 64'd1 << FRAC_BITS;
    return unity / ((speed_cfg == '0) ? 64'd1 : 64'(speed_cfg));
  endfunction

  function automatic vdd_item_t dissolve_voxel(input vdd_item_t v);
    vdd_item_t   r;
    logic [63:0] step;
    logic [63:0] fac;
    logic [63:0] nd;
    logic [63:0] mag;
    logic        neg;
    r    = v;
    step = decay_step();
    neg  = v.heat[DATA_WIDTH-1];
    mag  = neg ? 64'(data_t'(-v.heat)) : 64'(v.heat);
    if (exp_cfg) begin
      fac = (64'd1 << FRAC_BITS) - step;
      r.density = data_t'((64'(v.density) * fac) >> FRAC_BITS);
      if (heat_cfg) begin
        mag = (mag * fac) >> FRAC_BITS;
        r.heat = neg ? data_t'(-mag) : data_t'(mag);
      end
      if (color_cfg) begin
        r.red   = data_t'((64'(v.red) * fac) >> FRAC_BITS);
        r.green = data_t'((64'(v.green) * fac) >> FRAC_BITS);
        r.blue  = data_t'((64'(v.blue) * fac) >> FRAC_BITS);
      end
    end else begin
      nd = (64'(v.density) > step) ? 64'(v.density) - step : 64'd0;
      r.density = data_t'(nd);
      if (heat_cfg) begin
        // heat snaps to zero once its magnitude is under one step
        if (mag < step) r.heat = '0;
        else r.heat = neg ? data_t'(-(mag - step)) : data_t'(mag - step);
      end
      if (color_cfg && v.density != '0) begin
        r.red   = data_t'((64'(v.red) * nd) / 64'(v.density));
        r.green = data_t'((64'(v.green) * nd) / 64'(v.density));
        r.blue  = data_t'((64'(v.blue) * nd) / 64'(v.density));
      end
    end
    return r;
  endfunction

  // a value at one step, or one either side of it
  function automatic data_t near_step(input logic [63:0] step);
    return data_t'(step + 64'($urandom_range(0, 2)) - 64'd1);
  endfunction

  // ---------------- driver ----------------
  vdd_item_t offer_voxel = '0;
  logic      offer_on;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      offer_on = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        dissolved_q.push_back(dissolve_voxel(offer_voxel));
        offer_on = 1'b0;
      end
      if (!offer_on) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (voxel_q.size() != 0) begin
          offer_voxel = voxel_q.pop_front();
          offer_on = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left = $urandom_range(1, 8);
          end
        end
      end
      in_ch.valid        <= offer_on;
      in_ch.density_in   <= offer_voxel.density;
      in_ch.heat_in      <= offer_voxel.heat;
      in_ch.red_in       <= offer_voxel.red;
      in_ch.green_in     <= offer_voxel.green;
      in_ch.blue_in      <= offer_voxel.blue;
      in_ch.last_cell_in <= offer_voxel.last;
    end
  end

  // ---------------- receiver ----------------
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  logic [2:0] rx_tick = '0;

  always @(posedge clk) begin
    if (rst_n) begin
      rx_tick <= rx_tick + 3'd1;
      // one long hold-off while more than 60 voxels are still queued
      if (!hold_done && voxel_q.size() > 60) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(50, 300);
      end else begin
        rx_mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (rx_tick[1:0] != 2'd0);
        endcase
      end
    end
  end

  // ---------------- monitor ----------------
  vdd_item_t got_voxel;
  vdd_item_t want_voxel;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_voxel = {out_ch.density_out, data_t'(out_ch.heat_out), out_ch.red_out,
                   out_ch.green_out, out_ch.blue_out, out_ch.last_cell_out};
      if (dissolved_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("ERROR: word with nothing expected: %h", got_voxel);
      end else begin
        want_voxel = dissolved_q.pop_front();
        if (got_voxel !== want_voxel) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("ERROR: exp %h %h %h %h %h %b, got %h %h %h %h %h %b",
                     want_voxel.density, want_voxel.heat, want_voxel.red,
                     want_voxel.green, want_voxel.blue, want_voxel.last,
                     got_voxel.density, got_voxel.heat, got_voxel.red,
                     got_voxel.green, got_voxel.blue, got_voxel.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic wait_idle();
    do @(posedge clk);
    while (voxel_q.size() != 0 || in_ch.valid || dissolved_q.size() != 0);
  endtask

  task automatic write_reg(input vdd_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPEED:    speed_cfg = val;
      REG_EXP_MODE: exp_cfg   = val[0];
      REG_HEAT_EN:  heat_cfg  = val[0];
      default:      color_cfg = val[0];
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] spd, input logic expo,
                            input logic heat_on, input logic color_on);
    wait_idle();
    write_reg(REG_SPEED, spd);
    write_reg(REG_EXP_MODE, CFG_DATA_W'(expo));
    write_reg(REG_HEAT_EN, CFG_DATA_W'(heat_on));
    write_reg(REG_COLOR_EN, CFG_DATA_W'(color_on));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] spd;
    logic [63:0]           step;
    vdd_item_t             v;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.density_in   = '0;
    in_ch.heat_in      = '0;
    in_ch.red_in       = '0;
    in_ch.green_in     = '0;
    in_ch.blue_in      = '0;
    in_ch.last_cell_in = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner voxels under the corner settings
    for (int ph = 0; ph < 4; ph++) begin
      set_config(ProbeSpeed[ph], ProbeExp[ph], ProbeHeat[ph], ProbeColor[ph]);
      foreach (ProbeVoxels[k]) voxel_q.push_back(ProbeVoxels[k]);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case ($urandom_range(0, 9))
        0:       spd = 13'd0;
        1:       spd = 13'd1;
        2:       spd = 13'd4096;
        3:       spd = 13'd8191;
        4:       spd = 13'($urandom_range(4097, 8191));
        5:       spd = 13'($urandom_range(1, 4096));
        default: spd = 13'($urandom_range(2, 64));
      endcase
      set_config(spd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      step = decay_step();
      for (int i = 0; i < PhaseWords; i++) begin
        v = '0;
        case ($urandom_range(0, 5))
          0:       v.density = '0;
          1:       v.density = '1;
          2:       v.density = near_step(step);
          default: v.density = data_t'($urandom());
        endcase
        case ($urandom_range(0, 6))
          0:       v.heat = near_step(step);
          1:       v.heat = -near_step(step);
          2:       v.heat = 16'h8000;
          3:       v.heat = 16'h7FFF;
          default: v.heat = data_t'($urandom());
        endcase
        if ($urandom_range(0, 7) == 0) begin
          v.red   = '1;
          v.green = '0;
          v.blue  = '1;
        end else begin
          v.red   = data_t'($urandom());
          v.green = data_t'($urandom());
          v.blue  = data_t'($urandom());
        end
        v.last = 1'($urandom_range(0, 1));
        voxel_q.push_back(v);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (dissolved_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
